### hw/rtl/itfr_pkg.sv
// ----------------------------------------------------------------------------
// ISO-TP frame reassembler package
// Frame and result word layouts, status codes, PCI constants and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package itfr_pkg;

  // PCI frame types and data layout of classic CAN ISO-TP frames
  localparam logic [3:0] PCI_FIRST   = 4'h1;
  localparam logic [3:0] PCI_CONSEC  = 4'h2;
  localparam logic [2:0] FIRST_DATA  = 3'd6;
  localparam logic [2:0] CONSEC_DATA = 3'd7;
  localparam logic [2:0] FIRST_SRC   = 3'd2;
  localparam logic [2:0] CONSEC_SRC  = 3'd1;
  localparam logic [3:0] SEQ_START   = 4'd1;
  localparam logic [3:0] SEQ_LAST    = 4'hF;
  localparam int unsigned FRAME_BYTES = 8;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_FIRST  = 3'd1,
    ST_TOO_LONG   = 3'd2,
    ST_NOT_CONSEC = 3'd3,
    ST_SEQ        = 3'd4,
    ST_LEN        = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte0;
    logic [7:0] frame_byte1;
    logic [7:0] frame_byte2;
    logic [7:0] frame_byte3;
    logic [7:0] frame_byte4;
    logic [7:0] frame_byte5;
    logic [7:0] frame_byte6;
    logic [7:0] frame_byte7;
    logic       final_frame;
  } frame_t;

  typedef struct packed {
    status_e    status;
    logic [6:0] message_length;
    logic [5:0] byte_position;
    logic [7:0] payload_byte;
    logic       byte_present;
    logic       run_end;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_WRITE,
    S_CLOSE,
    S_EMIT,
    S_RD_REQ,
    S_RD_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic load_frame;
    logic eval;
    logic write_byte;
    logic close_msg;
    logic emit_single;
    logic emit_byte;
    logic next_byte;
    logic clear_msg;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_final;
    logic wr_done;
    logic single_result;
    logic drain_last;
    logic out_free;
  } dp_sts_t;

endpackage

### hw/rtl/itfr_if.sv
// ----------------------------------------------------------------------------
// ISO-TP reassembler channel interfaces
// Valid/ready channels for incoming CAN frames and outgoing result words.
// ----------------------------------------------------------------------------
interface itfr_frame_if;
  logic            valid;
  logic            ready;
  itfr_pkg::frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface itfr_result_if;
  logic             valid;
  logic             ready;
  itfr_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/itfr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module itfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write one word, read one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/itfr_ctrl.sv
// ----------------------------------------------------------------------------
// ISO-TP reassembler controller
// Sequences frame check, byte writes, message close and result drain.
// ----------------------------------------------------------------------------
module itfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                frame_valid_i,
  output logic                frame_ready_o,
  input  itfr_pkg::dp_sts_t   sts_i,
  output itfr_pkg::ctrl_cmd_t cmd_o
);
  import itfr_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    frame_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        frame_ready_o = 1'b1;
        if (frame_valid_i) begin
          cmd_o.load_frame = 1'b1;
          state_d          = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_WRITE;
      end
      S_WRITE: begin
        if (sts_i.wr_done) begin
          state_d = S_CLOSE;
        end else begin
          cmd_o.write_byte = 1'b1;
        end
      end
      S_CLOSE: begin
        if (sts_i.frame_final) begin
          cmd_o.close_msg = 1'b1;
          state_d         = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!sts_i.single_result) begin
          state_d = S_RD_REQ;
        end else if (sts_i.out_free) begin
          cmd_o.emit_single = 1'b1;
          cmd_o.clear_msg   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_RD_REQ: begin
        state_d = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_byte = 1'b1;
          if (sts_i.drain_last) begin
            cmd_o.clear_msg = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.next_byte = 1'b1;
            state_d         = S_RD_REQ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/itfr_dpath.sv
// ----------------------------------------------------------------------------
// ISO-TP reassembler datapath
// Frame register, message counters, error latch, payload store and the
// output word register.
// ----------------------------------------------------------------------------
module itfr_dpath #(
  parameter int unsigned MAX_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itfr_pkg::ctrl_cmd_t cmd_i,
  output itfr_pkg::dp_sts_t   sts_o,
  input  itfr_pkg::frame_t    frame_i,
  output itfr_pkg::result_t   result_o,
  output logic                result_valid_o,
  input  logic                result_ready_i
);
  import itfr_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_BYTES);
  localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);

  // message state
  logic             in_msg_q, in_msg_d;
  logic [CNT_W-1:0] decl_q, decl_d;
  logic [CNT_W-1:0] written_q, written_d;
  logic [3:0]       seq_q, seq_d;
  status_e          err_q, err_d;
  logic [2:0]       left_q, left_d;
  logic [2:0]       src_q, src_d;
  logic [AW-1:0]    rd_pos_q, rd_pos_d;
  logic             out_valid_q, out_valid_d;

  // payload registers
  frame_t           frame_q;
  result_t          out_q, out_d;

  logic [7:0]       frame_bytes [FRAME_BYTES];
  logic [11:0]      len12;
  logic [CNT_W-1:0] remaining;
  logic [7:0]       rdata;
  logic             out_free;
  logic             drain_last;

  assign frame_bytes[0] = frame_q.frame_byte0;
  assign frame_bytes[1] = frame_q.frame_byte1;
  assign frame_bytes[2] = frame_q.frame_byte2;
  assign frame_bytes[3] = frame_q.frame_byte3;
  assign frame_bytes[4] = frame_q.frame_byte4;
  assign frame_bytes[5] = frame_q.frame_byte5;
  assign frame_bytes[6] = frame_q.frame_byte6;
  assign frame_bytes[7] = frame_q.frame_byte7;

  assign len12      = {frame_q.frame_byte0[3:0], frame_q.frame_byte1};
  assign remaining  = decl_q - written_q;
  assign out_free   = !out_valid_q || result_ready_i;
  assign drain_last = (CNT_W'(rd_pos_q) + CNT_W'(1)) == decl_q;

  // payload store, one byte written per cycle
  itfr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_byte),
    .waddr_i (written_q[AW-1:0]),
    .wdata_i (frame_bytes[src_q]),
    .raddr_i (rd_pos_q),
    .rdata_o (rdata)
  );

  // check the frame, write bytes, close and clear the message
  always_comb begin
    in_msg_d  = in_msg_q;
    decl_d    = decl_q;
    written_d = written_q;
    seq_d     = seq_q;
    err_d     = err_q;
    left_d    = left_q;
    src_d     = src_q;
    rd_pos_d  = rd_pos_q;

    if (cmd_i.eval) begin
      left_d = 3'd0;
      if (!in_msg_q) begin
        in_msg_d  = 1'b1;
        seq_d     = SEQ_START;
        written_d = '0;
        decl_d    = '0;
        if (frame_q.frame_byte0[7:4] != PCI_FIRST) begin
          err_d = ST_NOT_FIRST;
        end else if (len12 > 12'(MAX_BYTES)) begin
          err_d = ST_TOO_LONG;
        end else begin
          decl_d = CNT_W'(len12);
          left_d = (len12 < 12'(FIRST_DATA)) ? len12[2:0] : FIRST_DATA;
          src_d  = FIRST_SRC;
        end
      end else if (err_q == ST_OK) begin
        if (frame_q.frame_byte0[7:4] != PCI_CONSEC) begin
          err_d = ST_NOT_CONSEC;
        end else if (frame_q.frame_byte0[3:0] != seq_q) begin
          err_d = ST_SEQ;
        end else begin
          left_d = (remaining >= CNT_W'(CONSEC_DATA)) ? CONSEC_DATA : remaining[2:0];
          src_d  = CONSEC_SRC;
          seq_d  = (seq_q == SEQ_LAST) ? SEQ_START : seq_q + 4'd1;
        end
      end
    end

    if (cmd_i.write_byte) begin
      written_d = written_q + CNT_W'(1);
      src_d     = src_q + 3'd1;
      left_d    = left_q - 3'd1;
    end

    if (cmd_i.close_msg) begin
      rd_pos_d = '0;
      if (err_q == ST_OK && written_q != decl_q) begin
        err_d = ST_LEN;
      end
    end

    if (cmd_i.next_byte) begin
      rd_pos_d = rd_pos_q + AW'(1);
    end

    if (cmd_i.clear_msg) begin
      in_msg_d  = 1'b0;
      decl_d    = '0;
      written_d = '0;
      seq_d     = SEQ_START;
      err_d     = ST_OK;
    end
  end

  // load the output word, drop it once taken
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (cmd_i.emit_single) begin
      out_d       = '{status: err_q, message_length: '0, byte_position: '0,
                     payload_byte: '0, byte_present: 1'b0, run_end: 1'b1};
      out_valid_d = 1'b1;
    end else if (cmd_i.emit_byte) begin
      out_d       = '{status: ST_OK, message_length: 7'(decl_q),
                     byte_position: 6'(rd_pos_q), payload_byte: rdata,
                     byte_present: 1'b1, run_end: drain_last};
      out_valid_d = 1'b1;
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q    <= 1'b0;
      decl_q      <= '0;
      written_q   <= '0;
      seq_q       <= SEQ_START;
      err_q       <= ST_OK;
      left_q      <= 3'd0;
      rd_pos_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_msg_q    <= in_msg_d;
      decl_q      <= decl_d;
      written_q   <= written_d;
      seq_q       <= seq_d;
      err_q       <= err_d;
      left_q      <= left_d;
      rd_pos_q    <= rd_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold frame, source index and output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_frame) begin
      frame_q <= frame_i;
    end
    src_q <= src_d;
    out_q <= out_d;
  end

  assign sts_o.frame_final   = frame_q.final_frame;
  assign sts_o.wr_done       = (left_q == 3'd0);
  assign sts_o.single_result = (err_q != ST_OK) || (decl_q == '0);
  assign sts_o.drain_last    = drain_last;
  assign sts_o.out_free      = out_free;

  assign result_o       = out_q;
  assign result_valid_o = out_valid_q;

endmodule

### hw/rtl/iso_tp_frame_reassembler.sv
// Flow: a frame is accepted in idle, then checked, its payload bytes are written to
//   the store and the frame is closed before the next frame is accepted.
// A final frame then emits a single error or empty-message word, or each payload word
//   after a registered store read and an output load, before the next frame.
// Reset: asynchronous, active low; clears message state and the output valid.
//   The payload store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// ISO-TP frame reassembler
// Rebuilds a multi-frame ISO-TP message from classic CAN frames and streams
// the payload out as byte words, or a single status word on error or for an empty message.
// ----------------------------------------------------------------------------
module iso_tp_frame_reassembler #(
  parameter int unsigned MAX_BYTES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  itfr_frame_if.sink           frame_i,
  itfr_result_if.source        result_o
);
  import itfr_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  itfr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_i.valid),
    .frame_ready_o (frame_i.ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  itfr_dpath #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .frame_i        (frame_i.data),
    .result_o       (result_o.data),
    .result_valid_o (result_o.valid),
    .result_ready_i (result_o.ready)
  );

endmodule
